>>> design/error_bounded_linear_segmenter_assert.svh
// Assertion macros shared by the segmenter checker.
`ifndef ERROR_BOUNDED_LINEAR_SEGMENTER_ASSERT_SVH
`define ERROR_BOUNDED_LINEAR_SEGMENTER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define EBLS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ebls assertion failed");

// Next-cycle implication, disabled during reset.
`define EBLS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ebls assertion failed");

`endif

>>> design/ebls_pkg.sv
// Types, constants and fixed-point helpers for the linear segmenter.
package ebls_pkg;

  localparam logic [31:0] ErrorBoundReset = 32'd65536;

  typedef struct packed {
    logic        func;
    logic [31:0] key;
  } in_t;

  typedef struct packed {
    logic [31:0]        start_key;
    logic [31:0]        stop_key;
    logic signed [63:0] slope;
    logic signed [63:0] intercept;
    logic               is_final;
    logic [31:0]        key_count;
  } out_t;

  typedef enum logic {
    OP_MUL = 1'b0,
    OP_DIV = 1'b1
  } mdu_op_e;

  typedef struct packed {
    logic         start;
    mdu_op_e      op;
    logic [127:0] opa;
    logic [127:0] opb;
  } mdu_req_t;

  typedef struct packed {
    logic         done;
    logic [127:0] res;
  } mdu_rsp_t;

  function automatic logic [63:0] sat64(input logic [127:0] w);
    logic [63:0] r;
    if (w[127:63] == {65{w[63]}}) begin
      r = w[63:0];
    end else if (w[127]) begin
      r = 64'h8000_0000_0000_0000;
    end else begin
      r = 64'h7FFF_FFFF_FFFF_FFFF;
    end
    return r;
  endfunction

  function automatic logic [127:0] sext64(input logic [63:0] v);
    return {{64{v[63]}}, v};
  endfunction

  function automatic logic [127:0] sar40(input logic [127:0] w);
    return {{40{w[127]}}, w[127:40]};
  endfunction

  function automatic logic [127:0] shl40(input logic [127:0] w);
    return {w[87:0], 40'd0};
  endfunction

  function automatic logic [63:0] kx(input logic [31:0] v);
    return {16'd0, v, 16'd0};
  endfunction

  function automatic logic slt128(input logic [127:0] a, input logic [127:0] b);
    return $signed(a) < $signed(b);
  endfunction

endpackage

>>> design/error_bounded_linear_segmenter.sv
// Greedy error-bounded piecewise linear segmenter: sequencer around one shared mul/div unit.
// A skipped, first or duplicate key needs no mul/div operation; divisions and multiplications
// run on the shared unit (one quotient or multiplier bit per cycle).
// A cone-opening key needs 3 divisions and 3 multiplies; an in-cone key needs
// 2 multiplies plus up to 2 line fits; a cone-closing emission adds 1 multiply and the output state.
// Input stalls until the sequencer is idle. Reset (async, active low) clears phase and position.
module error_bounded_linear_segmenter #(
  parameter int unsigned KEY_BITS = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  ebls_pkg::in_t   in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output ebls_pkg::out_t  out_data_o,
  input  logic            cfg_we_i,
  input  logic [31:0]     cfg_wdata_i
);

  localparam logic [31:0] KeyMask = (KEY_BITS >= 32) ? 32'hFFFF_FFFF :
                                    32'((64'd1 << KEY_BITS) - 64'd1);

  typedef enum logic [16:0] {
    ST_IDLE         = 17'h00001,
    ST_FIT_DIV_GO   = 17'h00002,
    ST_FIT_DIV_WAIT = 17'h00004,
    ST_FIT_MUL_GO   = 17'h00008,
    ST_FIT_MUL_WAIT = 17'h00010,
    ST_PIV_DIV_GO   = 17'h00020,
    ST_PIV_DIV_WAIT = 17'h00040,
    ST_PIV_MUL_GO   = 17'h00080,
    ST_PIV_MUL_WAIT = 17'h00100,
    ST_LO_MUL_GO    = 17'h00200,
    ST_LO_MUL_WAIT  = 17'h00400,
    ST_UP_MUL_GO    = 17'h00800,
    ST_UP_MUL_WAIT  = 17'h01000,
    ST_COMPARE      = 17'h02000,
    ST_EM_MUL_GO    = 17'h04000,
    ST_EM_MUL_WAIT  = 17'h08000,
    ST_OUT          = 17'h10000
  } state_e;

  typedef enum logic [3:0] {
    PH_NEED2 = 4'b0001,
    PH_NEED1 = 4'b0010,
    PH_READY = 4'b0100,
    PH_DONE  = 4'b1000
  } phase_e;

  typedef enum logic [1:0] {
    FJ_OPEN_LO = 2'd0,
    FJ_OPEN_UP = 2'd1,
    FJ_UPD_UP  = 2'd2,
    FJ_UPD_LO  = 2'd3
  } fit_job_e;

  state_e   state_q, state_d;
  phase_e   phase_q, phase_d;
  fit_job_e fit_job_q, fit_job_d;
  logic        out_valid_q, out_valid_d;
  logic [31:0] position_q, position_d;
  logic [31:0] error_bound_q;

  logic [31:0] previous_key_q, previous_key_d;
  logic [31:0] last_key_q, last_key_d;
  logic [31:0] anchor_key_q, anchor_key_d;
  logic [31:0] anchor_pos_q, anchor_pos_d;
  logic [31:0] second_key_q, second_key_d;
  logic [31:0] second_pos_q, second_pos_d;
  logic [63:0] up_a_q, up_a_d, up_b_q, up_b_d;
  logic [63:0] lo_a_q, lo_a_d, lo_b_q, lo_b_d;
  logic [63:0] piv_x_q, piv_x_d, piv_y_q, piv_y_d;
  logic [63:0] cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic [63:0] fx1_q, fx1_d, fy1_q, fy1_d, fx2_q, fx2_d, fy2_q, fy2_d;
  logic [63:0] fa_q, fa_d;
  logic        upd_lo_q, upd_lo_d;
  logic [127:0] lline_q, lline_d, uline_q, uline_d;
  logic [31:0] em_start_q, em_start_d, em_stop_q, em_stop_d, em_count_q, em_count_d;
  logic [63:0] em_slope_q, em_slope_d, em_icpt_q, em_icpt_d;
  logic        em_fin_q, em_fin_d;
  ebls_pkg::out_t out_q, out_d;

  ebls_pkg::mdu_req_t mdu_req;
  ebls_pkg::mdu_rsp_t mdu_rsp;

  logic [31:0]  key_m;
  logic [63:0]  g64;
  logic [64:0]  slope_sum;
  logic [63:0]  avg_w;
  logic [63:0]  fit_b_w;
  logic [127:0] y_w, yp_w, ym_w;
  logic         inside_w, upd_up_w, upd_lo_w, keep_w;

  ebls_muldiv u_muldiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mdu_req),
    .rsp_o  (mdu_rsp)
  );

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    key_m     = in_data_i.key & KeyMask;
    g64       = {32'd0, error_bound_q};
    slope_sum = {up_a_q[63], up_a_q} + {lo_a_q[63], lo_a_q};
    avg_w     = slope_sum[64:1];
    fit_b_w   = ebls_pkg::sat64(ebls_pkg::sext64(fy1_q) - ebls_pkg::sar40(mdu_rsp.res));
    y_w       = ebls_pkg::shl40(ebls_pkg::sext64(cur_y_q));
    yp_w      = ebls_pkg::shl40(ebls_pkg::sext64(cur_y_q + g64));
    ym_w      = ebls_pkg::shl40(ebls_pkg::sext64(cur_y_q - g64));
    inside_w  = ebls_pkg::slt128(lline_q, y_w) && ebls_pkg::slt128(y_w, uline_q);
    upd_up_w  = ebls_pkg::slt128(yp_w, uline_q);
    upd_lo_w  = ebls_pkg::slt128(lline_q, ym_w);
    keep_w    = !(em_start_q == 32'd0 && em_slope_q == 64'd0 && em_icpt_q == 64'd0);
  end

  always_comb begin
    mdu_req       = '0;
    mdu_req.op    = ebls_pkg::OP_MUL;
    unique case (state_q)
      ST_FIT_DIV_GO: begin
        mdu_req.start = 1'b1;
        mdu_req.op    = ebls_pkg::OP_DIV;
        mdu_req.opa   = ebls_pkg::shl40(ebls_pkg::sext64(fy2_q) - ebls_pkg::sext64(fy1_q));
        mdu_req.opb   = ebls_pkg::sext64(fx2_q) - ebls_pkg::sext64(fx1_q);
      end
      ST_FIT_MUL_GO: begin
        mdu_req.start = 1'b1;
        mdu_req.opa   = {64'd0, fa_q};
        mdu_req.opb   = {64'd0, fx1_q};
      end
      ST_PIV_DIV_GO: begin
        mdu_req.start = 1'b1;
        mdu_req.op    = ebls_pkg::OP_DIV;
        mdu_req.opa   = ebls_pkg::shl40(ebls_pkg::sext64(lo_b_q) - ebls_pkg::sext64(up_b_q));
        mdu_req.opb   = ebls_pkg::sext64(up_a_q) - ebls_pkg::sext64(lo_a_q);
      end
      ST_PIV_MUL_GO: begin
        mdu_req.start = 1'b1;
        mdu_req.opa   = {64'd0, up_a_q};
        mdu_req.opb   = {64'd0, piv_x_q};
      end
      ST_LO_MUL_GO: begin
        mdu_req.start = 1'b1;
        mdu_req.opa   = {64'd0, lo_a_q};
        mdu_req.opb   = {64'd0, cur_x_q};
      end
      ST_UP_MUL_GO: begin
        mdu_req.start = 1'b1;
        mdu_req.opa   = {64'd0, up_a_q};
        mdu_req.opb   = {64'd0, cur_x_q};
      end
      ST_EM_MUL_GO: begin
        mdu_req.start = 1'b1;
        mdu_req.opa   = {64'd0, em_slope_q};
        mdu_req.opb   = {64'd0, piv_x_q};
      end
      default: begin
        mdu_req.start = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_d        = state_q;
    phase_d        = phase_q;
    fit_job_d      = fit_job_q;
    out_valid_d    = out_valid_q && out_stall_i;
    position_d     = position_q;
    previous_key_d = previous_key_q;
    last_key_d     = last_key_q;
    anchor_key_d   = anchor_key_q;
    anchor_pos_d   = anchor_pos_q;
    second_key_d   = second_key_q;
    second_pos_d   = second_pos_q;
    up_a_d = up_a_q;  up_b_d = up_b_q;
    lo_a_d = lo_a_q;  lo_b_d = lo_b_q;
    piv_x_d = piv_x_q;  piv_y_d = piv_y_q;
    cur_x_d = cur_x_q;  cur_y_d = cur_y_q;
    fx1_d = fx1_q;  fy1_d = fy1_q;  fx2_d = fx2_q;  fy2_d = fy2_q;
    fa_d       = fa_q;
    upd_lo_d   = upd_lo_q;
    lline_d    = lline_q;
    uline_d    = uline_q;
    em_start_d = em_start_q;
    em_stop_d  = em_stop_q;
    em_count_d = em_count_q;
    em_slope_d = em_slope_q;
    em_icpt_d  = em_icpt_q;
    em_fin_d   = em_fin_q;
    out_d      = out_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (!in_data_i.func) begin
            position_d     = position_q + 32'd1;
            previous_key_d = key_m;
            if (position_q == 32'd0 || previous_key_q != key_m) begin
              last_key_d = key_m;
              unique case (phase_q)
                PH_NEED2: begin
                  anchor_key_d = key_m;
                  anchor_pos_d = position_q;
                  phase_d      = PH_NEED1;
                end
                PH_NEED1: begin
                  second_key_d = key_m;
                  second_pos_d = position_q;
                  phase_d      = PH_READY;
                  fx1_d        = ebls_pkg::kx(anchor_key_q);
                  fy1_d        = ebls_pkg::kx(anchor_pos_q) + g64;
                  fx2_d        = ebls_pkg::kx(key_m);
                  fy2_d        = ebls_pkg::kx(position_q) - g64;
                  fit_job_d    = FJ_OPEN_LO;
                  state_d      = ST_FIT_DIV_GO;
                end
                PH_READY: begin
                  cur_x_d = ebls_pkg::kx(key_m);
                  cur_y_d = ebls_pkg::kx(position_q);
                  state_d = ST_LO_MUL_GO;
                end
                default: begin
                  phase_d = phase_q;
                end
              endcase
            end
          end else begin
            em_fin_d   = 1'b1;
            em_count_d = position_q;
            em_start_d = anchor_key_q;
            phase_d    = PH_DONE;
            if (phase_q == PH_NEED1) begin
              em_stop_d  = anchor_key_q + 32'd1;
              em_slope_d = 64'd0;
              em_icpt_d  = ebls_pkg::kx(anchor_pos_q);
              state_d    = ST_OUT;
            end else if (phase_q == PH_READY) begin
              em_stop_d  = last_key_q;
              em_slope_d = avg_w;
              state_d    = ST_EM_MUL_GO;
            end
          end
        end
      end
      ST_FIT_DIV_GO: state_d = ST_FIT_DIV_WAIT;
      ST_FIT_DIV_WAIT: begin
        if (mdu_rsp.done) begin
          fa_d    = ebls_pkg::sat64(mdu_rsp.res);
          state_d = ST_FIT_MUL_GO;
        end
      end
      ST_FIT_MUL_GO: state_d = ST_FIT_MUL_WAIT;
      ST_FIT_MUL_WAIT: begin
        if (mdu_rsp.done) begin
          unique case (fit_job_q)
            FJ_OPEN_LO: begin
              lo_a_d    = fa_q;
              lo_b_d    = fit_b_w;
              fx1_d     = ebls_pkg::kx(anchor_key_q);
              fy1_d     = ebls_pkg::kx(anchor_pos_q) - g64;
              fx2_d     = ebls_pkg::kx(second_key_q);
              fy2_d     = ebls_pkg::kx(second_pos_q) + g64;
              fit_job_d = FJ_OPEN_UP;
              state_d   = ST_FIT_DIV_GO;
            end
            FJ_OPEN_UP: begin
              up_a_d  = fa_q;
              up_b_d  = fit_b_w;
              state_d = ST_PIV_DIV_GO;
            end
            FJ_UPD_UP: begin
              up_a_d = fa_q;
              up_b_d = fit_b_w;
              if (upd_lo_q) begin
                fx1_d     = piv_x_q;
                fy1_d     = piv_y_q;
                fx2_d     = cur_x_q;
                fy2_d     = cur_y_q - g64;
                fit_job_d = FJ_UPD_LO;
                state_d   = ST_FIT_DIV_GO;
              end else begin
                state_d = ST_IDLE;
              end
            end
            FJ_UPD_LO: begin
              lo_a_d  = fa_q;
              lo_b_d  = fit_b_w;
              state_d = ST_IDLE;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_PIV_DIV_GO: state_d = ST_PIV_DIV_WAIT;
      ST_PIV_DIV_WAIT: begin
        if (mdu_rsp.done) begin
          piv_x_d = ebls_pkg::sat64(mdu_rsp.res);
          state_d = ST_PIV_MUL_GO;
        end
      end
      ST_PIV_MUL_GO: state_d = ST_PIV_MUL_WAIT;
      ST_PIV_MUL_WAIT: begin
        if (mdu_rsp.done) begin
          piv_y_d = ebls_pkg::sat64(ebls_pkg::sar40(mdu_rsp.res) + ebls_pkg::sext64(up_b_q));
          state_d = ST_IDLE;
        end
      end
      ST_LO_MUL_GO: state_d = ST_LO_MUL_WAIT;
      ST_LO_MUL_WAIT: begin
        if (mdu_rsp.done) begin
          lline_d = mdu_rsp.res + ebls_pkg::shl40(ebls_pkg::sext64(lo_b_q));
          state_d = ST_UP_MUL_GO;
        end
      end
      ST_UP_MUL_GO: state_d = ST_UP_MUL_WAIT;
      ST_UP_MUL_WAIT: begin
        if (mdu_rsp.done) begin
          uline_d = mdu_rsp.res + ebls_pkg::shl40(ebls_pkg::sext64(up_b_q));
          state_d = ST_COMPARE;
        end
      end
      ST_COMPARE: begin
        upd_lo_d = upd_lo_w;
        if (!inside_w) begin
          em_start_d   = anchor_key_q;
          em_stop_d    = last_key_q;
          em_slope_d   = avg_w;
          em_fin_d     = 1'b0;
          em_count_d   = 32'd0;
          anchor_key_d = last_key_q;
          anchor_pos_d = cur_y_q[47:16];
          phase_d      = PH_NEED1;
          state_d      = ST_EM_MUL_GO;
        end else if (upd_up_w) begin
          fx1_d     = piv_x_q;
          fy1_d     = piv_y_q;
          fx2_d     = cur_x_q;
          fy2_d     = cur_y_q + g64;
          fit_job_d = FJ_UPD_UP;
          state_d   = ST_FIT_DIV_GO;
        end else if (upd_lo_w) begin
          fx1_d     = piv_x_q;
          fy1_d     = piv_y_q;
          fx2_d     = cur_x_q;
          fy2_d     = cur_y_q - g64;
          fit_job_d = FJ_UPD_LO;
          state_d   = ST_FIT_DIV_GO;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_EM_MUL_GO: state_d = ST_EM_MUL_WAIT;
      ST_EM_MUL_WAIT: begin
        if (mdu_rsp.done) begin
          em_icpt_d = ebls_pkg::sat64(ebls_pkg::sext64(piv_y_q) -
                                      ebls_pkg::sar40(mdu_rsp.res));
          state_d   = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          if (keep_w) begin
            out_valid_d     = 1'b1;
            out_d.start_key = em_start_q;
            out_d.stop_key  = em_stop_q;
            out_d.slope     = em_slope_q;
            out_d.intercept = em_icpt_q;
            out_d.is_final  = em_fin_q;
            out_d.key_count = em_count_q;
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      phase_q       <= PH_NEED2;
      fit_job_q     <= FJ_OPEN_LO;
      out_valid_q   <= 1'b0;
      position_q    <= 32'd0;
      error_bound_q <= ebls_pkg::ErrorBoundReset;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      fit_job_q   <= fit_job_d;
      out_valid_q <= out_valid_d;
      position_q  <= position_d;
      if (cfg_we_i) begin
        error_bound_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    previous_key_q <= previous_key_d;
    last_key_q     <= last_key_d;
    anchor_key_q   <= anchor_key_d;
    anchor_pos_q   <= anchor_pos_d;
    second_key_q   <= second_key_d;
    second_pos_q   <= second_pos_d;
    up_a_q  <= up_a_d;   up_b_q  <= up_b_d;
    lo_a_q  <= lo_a_d;   lo_b_q  <= lo_b_d;
    piv_x_q <= piv_x_d;  piv_y_q <= piv_y_d;
    cur_x_q <= cur_x_d;  cur_y_q <= cur_y_d;
    fx1_q <= fx1_d;  fy1_q <= fy1_d;  fx2_q <= fx2_d;  fy2_q <= fy2_d;
    fa_q       <= fa_d;
    upd_lo_q   <= upd_lo_d;
    lline_q    <= lline_d;
    uline_q    <= uline_d;
    em_start_q <= em_start_d;
    em_stop_q  <= em_stop_d;
    em_count_q <= em_count_d;
    em_slope_q <= em_slope_d;
    em_icpt_q  <= em_icpt_d;
    em_fin_q   <= em_fin_d;
    out_q      <= out_d;
  end

endmodule

>>> design/ebls_muldiv.sv
// Shared iterative unit: 64x64 signed multiply and 128/128 signed divide, one bit per cycle.
module ebls_muldiv (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ebls_pkg::mdu_req_t  req_i,
  output ebls_pkg::mdu_rsp_t  rsp_o
);

  typedef enum logic [3:0] {
    MS_IDLE = 4'b0001,
    MS_MUL  = 4'b0010,
    MS_DIV  = 4'b0100,
    MS_FIX  = 4'b1000
  } mstate_e;

  mstate_e      state_q, state_d;
  logic [6:0]   cnt_q, cnt_d;
  logic         done_q, done_d;
  logic [127:0] work_q, work_d;
  logic [127:0] rem_q, rem_d;
  logic [127:0] den_q, den_d;
  logic         neg_q, neg_d;
  logic [127:0] res_q, res_d;

  logic [63:0]  mag_a64, mag_b64;
  logic [127:0] mag_a128, mag_b128;
  logic [64:0]  mul_sum;
  logic [128:0] div_sh, div_diff;
  logic         div_ge;

  always_comb begin
    mag_a64  = req_i.opa[63] ? 64'd0 - req_i.opa[63:0] : req_i.opa[63:0];
    mag_b64  = req_i.opb[63] ? 64'd0 - req_i.opb[63:0] : req_i.opb[63:0];
    mag_a128 = req_i.opa[127] ? 128'd0 - req_i.opa : req_i.opa;
    mag_b128 = req_i.opb[127] ? 128'd0 - req_i.opb : req_i.opb;
    mul_sum  = {1'b0, work_q[127:64]} + (work_q[0] ? {1'b0, den_q[63:0]} : 65'd0);
    div_sh   = {rem_q, work_q[127]};
    div_diff = div_sh - {1'b0, den_q};
    div_ge   = !div_diff[128];
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    work_d  = work_q;
    rem_d   = rem_q;
    den_d   = den_q;
    neg_d   = neg_q;
    res_d   = res_q;
    unique case (state_q)
      MS_IDLE: begin
        if (req_i.start) begin
          if (req_i.op == ebls_pkg::OP_MUL) begin
            work_d  = {64'd0, mag_b64};
            den_d   = {64'd0, mag_a64};
            neg_d   = req_i.opa[63] ^ req_i.opb[63];
            cnt_d   = 7'd63;
            state_d = MS_MUL;
          end else if (mag_b128 == 128'd0) begin
            work_d  = 128'd0;
            neg_d   = 1'b0;
            state_d = MS_FIX;
          end else begin
            work_d  = mag_a128;
            rem_d   = 128'd0;
            den_d   = mag_b128;
            neg_d   = req_i.opa[127] ^ req_i.opb[127];
            cnt_d   = 7'd127;
            state_d = MS_DIV;
          end
        end
      end
      MS_MUL: begin
        work_d = {mul_sum, work_q[63:1]};
        cnt_d  = cnt_q - 7'd1;
        if (cnt_q == 7'd0) begin
          state_d = MS_FIX;
        end
      end
      MS_DIV: begin
        rem_d  = div_ge ? div_diff[127:0] : div_sh[127:0];
        work_d = {work_q[126:0], div_ge};
        cnt_d  = cnt_q - 7'd1;
        if (cnt_q == 7'd0) begin
          state_d = MS_FIX;
        end
      end
      MS_FIX: begin
        res_d   = neg_q ? 128'd0 - work_q : work_q;
        done_d  = 1'b1;
        state_d = MS_IDLE;
      end
      default: begin
        state_d = MS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= MS_IDLE;
      cnt_q   <= 7'd0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
    neg_q  <= neg_d;
    res_q  <= res_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.res  = res_q;

endmodule

>>> design/ebls_checker.sv
// Port-level checker for the linear segmenter, bound to the top level.
`include "error_bounded_linear_segmenter_assert.svh"

module ebls_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input ebls_pkg::out_t out_data_o
);

  `EBLS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o))
  `EBLS_ASSERT_IMPLY(a_count_final, clk_i, rst_ni, out_valid_o && !out_data_o.is_final, out_data_o.key_count == 32'd0)
  `EBLS_ASSERT_IMPLY(a_no_null_seg, clk_i, rst_ni, out_valid_o, !(out_data_o.start_key == 32'd0 && out_data_o.slope == 64'sd0 && out_data_o.intercept == 64'sd0))

endmodule

bind error_bounded_linear_segmenter ebls_checker u_ebls_checker (.*);

>>> tb/segment_checker.sv
// Checker for the linear segmenter: predicts segments from accepted keys and compares them.
`timescale 1ns / 1ps
module segment_checker (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_stall_i,
  input  ebls_pkg::in_t  in_data_i,
  input  logic           out_valid_i,
  input  logic           out_stall_i,
  input  ebls_pkg::out_t out_data_i,
  input  logic           cfg_we_i,
  input  logic [31:0]    cfg_wdata_i,
  output int             pending_o,
  output int             fail_count_o,
  output int             seg_count_o
);

  typedef logic signed [127:0] w_t;
  typedef logic signed [63:0]  s64_t;
  typedef enum logic [1:0] {NEED_TWO, NEED_ONE, CONE_OPEN, FINISHED} seg_phase_e;

  localparam s64_t S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam s64_t S64_MIN = 64'sh8000_0000_0000_0000;

  logic [31:0]    gamma;
  seg_phase_e     ph;
  logic [31:0]    anc_key, anc_pos, sec_key, sec_pos, last_k, prev_k, pos;
  s64_t           up_a, up_b, lo_a, lo_b, piv_x, piv_y;
  ebls_pkg::out_t segment_q[$];
  int             fails, segs;

  assign pending_o    = segment_q.size();
  assign fail_count_o = fails;
  assign seg_count_o  = segs;

  function automatic w_t ext(input s64_t v);
    return w_t'(v);
  endfunction

  function automatic s64_t sat(input w_t w);
    if (w[127:63] == '0 || w[127:63] == '1) return w[63:0];
    return w[127] ? S64_MIN : S64_MAX;
  endfunction

  function automatic w_t quot(input w_t n, input w_t d);
    if (d == 0) return 0;
    return n / d;
  endfunction

  function automatic s64_t fixed_key(input logic [31:0] k);
    return $signed({16'd0, k, 16'd0});
  endfunction

  function automatic w_t line_at(input s64_t a, input s64_t b, input s64_t x);
    return ext(a) * ext(x) + (ext(b) <<< 40);
  endfunction

  function automatic void fit(input s64_t x1, input s64_t y1, input s64_t x2,
                              input s64_t y2, output s64_t a, output s64_t b);
    a = sat(quot((ext(y2) - ext(y1)) <<< 40, ext(x2) - ext(x1)));
    b = sat(ext(y1) - ((ext(a) * ext(x1)) >>> 40));
  endfunction

  function automatic bit make_seg(input logic [31:0] start, input logic [31:0] stop,
                                  input s64_t a, input s64_t b, input bit fin,
                                  output ebls_pkg::out_t r);
    r = '0;
    if (start == 0 && a == 0 && b == 0) return 0;
    r.start_key = start;
    r.stop_key  = stop;
    r.slope     = a;
    r.intercept = b;
    r.is_final  = fin;
    r.key_count = fin ? pos : 32'd0;
    return 1;
  endfunction

  function automatic bit close_cone(input bit fin, output ebls_pkg::out_t r);
    s64_t avg, icpt;
    avg  = sat((ext(up_a) + ext(lo_a)) >>> 1);
    icpt = sat(ext(piv_y) - ((ext(avg) * ext(piv_x)) >>> 40));
    return make_seg(anc_key, last_k, avg, icpt, fin, r);
  endfunction

  function automatic bit add_point(input logic [31:0] k, input logic [31:0] p,
                                   output ebls_pkg::out_t r);
    s64_t g, x, y, x0, y0, x1, y1;
    bit   hit;
    g = s64_t'({32'd0, gamma});
    x = fixed_key(k);
    y = fixed_key(p);
    r = '0;
    last_k = k;
    case (ph)
      NEED_TWO: begin
        anc_key = k; anc_pos = p; ph = NEED_ONE;
        return 0;
      end
      NEED_ONE: begin
        sec_key = k; sec_pos = p;
        x0 = fixed_key(anc_key); y0 = fixed_key(anc_pos);
        x1 = fixed_key(sec_key); y1 = fixed_key(sec_pos);
        fit(x0, y0 + g, x1, y1 - g, lo_a, lo_b);
        fit(x0, y0 - g, x1, y1 + g, up_a, up_b);
        piv_x = sat(quot((ext(lo_b) - ext(up_b)) <<< 40, ext(up_a) - ext(lo_a)));
        piv_y = sat(((ext(up_a) * ext(piv_x)) >>> 40) + ext(up_b));
        ph = CONE_OPEN;
        return 0;
      end
      CONE_OPEN: begin
        if (!(line_at(lo_a, lo_b, x) < (ext(y) <<< 40) &&
              (ext(y) <<< 40) < line_at(up_a, up_b, x))) begin
          hit = close_cone(1'b0, r);
          anc_key = k; anc_pos = p; ph = NEED_ONE;
          return hit;
        end
        if ((ext(y + g) <<< 40) < line_at(up_a, up_b, x))
          fit(piv_x, piv_y, x, y + g, up_a, up_b);
        if (line_at(lo_a, lo_b, x) < (ext(y - g) <<< 40))
          fit(piv_x, piv_y, x, y - g, lo_a, lo_b);
        return 0;
      end
      default: return 0;
    endcase
  endfunction

  function automatic bit predict(input ebls_pkg::in_t t, output ebls_pkg::out_t r);
    bit hit;
    r = '0;
    hit = 0;
    if (t.func == 1'b0) begin
      if (pos == 0 || prev_k != t.key) hit = add_point(t.key, pos, r);
      prev_k = t.key;
      pos = pos + 1;
      return hit;
    end
    if (ph == NEED_ONE)
      hit = make_seg(anc_key, anc_key + 1, 0, fixed_key(anc_pos), 1'b1, r);
    else if (ph == CONE_OPEN)
      hit = close_cone(1'b1, r);
    ph = FINISHED;
    return hit;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    ebls_pkg::out_t exp_seg, got;
    if (!rst_ni) begin
      gamma = ebls_pkg::ErrorBoundReset;
      ph = NEED_TWO;
      {anc_key, anc_pos, sec_key, sec_pos, last_k, prev_k, pos} = '0;
      {up_a, up_b, lo_a, lo_b, piv_x, piv_y} = '0;
      segment_q.delete();
      fails = 0;
      segs = 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        if (predict(in_data_i, exp_seg)) segment_q.insert(segment_q.size(), exp_seg);
      end
      if (cfg_we_i) gamma = cfg_wdata_i;
      if (out_valid_i && !out_stall_i) begin
        got = out_data_i;
        segs++;
        if (segment_q.size() == 0) begin
          fails++;
          if (fails <= 10) $display("unexpected segment: %p", got);
        end else begin
          exp_seg = segment_q.pop_front();
          if (got !== exp_seg) begin
            fails++;
            if (fails <= 10) begin
              $display("segment mismatch at %0t", $realtime);
              $display("  exp start %h stop %h slope %h icpt %h fin %b cnt %0d",
                       exp_seg.start_key, exp_seg.stop_key, exp_seg.slope,
                       exp_seg.intercept, exp_seg.is_final, exp_seg.key_count);
              $display("  got start %h stop %h slope %h icpt %h fin %b cnt %0d",
                       got.start_key, got.stop_key, got.slope, got.intercept,
                       got.is_final, got.key_count);
            end
          end
        end
      end
    end
  end
endmodule

>>> tb/testbench.sv
// Top of the segmenter testbench: clock, reset, key stimulus, error bound phases and verdict.
`timescale 1ns / 1ps
module testbench;

  localparam int LIMIT   = 6000000;
  localparam int SETTLE  = 1000;

  logic           clk_i = 0;
  logic           rst_ni = 0;
  logic           in_valid_i = 0;
  logic           in_stall_o;
  ebls_pkg::in_t  in_data_i = '0;
  logic           out_valid_o;
  logic           out_stall_i = 0;
  ebls_pkg::out_t out_data_o;
  logic           cfg_we_i = 0;
  logic [31:0]    cfg_wdata_i = '0;
  int             pending, fails, segs, cycles, sent;
  logic [31:0]    cur_key;

  always #1 clk_i = ~clk_i;

  error_bounded_linear_segmenter dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o, .cfg_we_i, .cfg_wdata_i
  );

  segment_checker checker_i (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_i(in_stall_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_stall_i, .out_data_i(out_data_o),
    .cfg_we_i, .cfg_wdata_i,
    .pending_o(pending), .fail_count_o(fails), .seg_count_o(segs)
  );

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // receiver stalls, with quiet stretches
  initial begin
    int n;
    forever begin
      @(negedge clk_i);
      if ($urandom_range(0, 3) == 0) begin
        out_stall_i <= 1'b1;
        n = gap_len();
        repeat (n) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end else begin
        repeat ($urandom_range(1, 30)) @(negedge clk_i);
      end
    end
  end

  task automatic send(input logic func, input logic [31:0] k, input bit quiet);
    int n;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= '{func: func, key: k};
    do @(posedge clk_i); while (in_stall_o);
    sent++;
    n = quiet ? 0 : gap_len();
    if (n > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (n - 1) @(negedge clk_i);
    end
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic set_bound(input logic [31:0] v);
    drain();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic key(input logic [31:0] k);
    send(1'b0, k, 1'b0);
  endtask

  task automatic random_keys(input int count);
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 12) begin
      end else if (r < 55) cur_key += $urandom_range(1, 20);
      else if (r < 80) cur_key += $urandom_range(1, 1000);
      else if (r < 95) cur_key += $urandom_range(1, 1 << 20);
      else if (r < 97) cur_key += $urandom;
      else cur_key = $urandom;
      send(1'b0, cur_key, i % 97 < 20);
    end
  endtask

  initial begin
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    set_bound(ebls_pkg::ErrorBoundReset);
    key(32'd0); key(32'd0); key(32'd1); key(32'd2); key(32'd3);
    key(32'd100); key(32'd101); key(32'd5000); key(32'd5000);
    key(32'd9); key(32'd20); key(32'd9); key(32'd9);
    key(32'hFFFF_FFFF); key(32'hFFFF_FFFE); key(32'hFFFF_FFFF);
    key(32'h5555_5555); key(32'hAAAA_AAAA); key(32'hAAAA_AAAB);
    cur_key = 32'hAAAA_AAAB;

    set_bound(32'd0);
    random_keys(180);
    set_bound(32'hFFFF_FFFF);
    random_keys(140);
    set_bound(32'h0004_0000);
    random_keys(180);
    set_bound($urandom_range(1, 32'h0002_0000));
    random_keys(200);

    send(1'b1, $urandom, 1'b0);
    key(cur_key + 1);
    key(cur_key + 7);
    send(1'b1, 32'd0, 1'b0);

    drain();
    $display("Summary: %0d transactions sent, %0d segments checked, five error bounds",
             sent, segs);
    $display("  from zero to full scale, with duplicate, descending and extreme keys.");
    if (fails == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
